>>> rtl/mcqc_pkg.sv
// mcqc_pkg: shared types and constants for the multi-channel quadrature counter
// command codes, register indexes, x4 transition table, lane request/status structs
// no dependencies
package mcqc_pkg;

  localparam int PosW   = 32;
  localparam int PhaseW = 2;
  localparam int CmdW   = 3;
  localparam int ChanW  = 2;
  localparam int PinW   = 6;
  localparam int CfgIdxW = 3;
  localparam int NumBasePins = 4;

  localparam logic [CmdW-1:0] CMD_EDGE    = 3'd0;
  localparam logic [CmdW-1:0] CMD_READ    = 3'd1;
  localparam logic [CmdW-1:0] CMD_RESET   = 3'd2;
  localparam logic [CmdW-1:0] CMD_ENABLE  = 3'd3;
  localparam logic [CmdW-1:0] CMD_DISABLE = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_PIN_0    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_PIN_1    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BASE_PIN_2    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BASE_PIN_3    = 3'd4;

  // index is {last_phase, new_phase}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [PhaseW-1:0] phase;
    logic              configured;
    logic              pin_match;
  } lane_req_t;

  typedef struct packed {
    logic            accepted;
    logic [PosW-1:0] position;
  } lane_stat_t;

endpackage

>>> rtl/mcqc_lane.sv
// mcqc_lane: state of one encoder channel (count, last phase, enable) and its update
// depends on mcqc_pkg
module mcqc_lane import mcqc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       sel,
  input  lane_req_t  req,
  output lane_stat_t stat
);

  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic              en_r, en_nxt;
  logic signed [1:0] delta;

  assign delta = STEP_TABLE[{phase_r, req.phase}];

  always_comb begin
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    en_nxt        = en_r;
    stat.accepted = 1'b0;
    unique case (req.command)
      CMD_EDGE: begin
        if (req.configured && en_r && req.pin_match) begin
          pos_nxt       = pos_r + PosW'(signed'(delta));
          phase_nxt     = req.phase;
          stat.accepted = 1'b1;
        end
      end
      CMD_READ: begin
        stat.accepted = 1'b1;
      end
      CMD_RESET: begin
        pos_nxt = '0;
        if (req.configured) begin
          phase_nxt = req.phase;
        end
        stat.accepted = 1'b1;
      end
      CMD_ENABLE: begin
        if (req.configured) begin
          pos_nxt       = '0;
          phase_nxt     = req.phase;
          en_nxt        = 1'b1;
          stat.accepted = 1'b1;
        end
      end
      CMD_DISABLE: begin
        if (req.configured) begin
          en_nxt        = 1'b0;
          stat.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    stat.position = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= '0;
      en_r    <= 1'b0;
    end else if (sel) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      en_r    <= en_nxt;
    end
  end

endmodule

>>> rtl/multi_channel_quadrature_counter.sv
// multi_channel_quadrature_counter: x4 quadrature counter for up to four encoder channels
// a request is held in the input register, its result in the result register
// throughput: one request per cycle unless out_ready stalls; lane update is combinational
// reset: counts, phases, enable bits and configuration registers all clear at once
// depends on mcqc_pkg and mcqc_lane
module multi_channel_quadrature_counter import mcqc_pkg::*; #(
  parameter int CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CmdW-1:0]    in_command,
  input  logic [ChanW-1:0]   in_channel,
  input  logic [PinW-1:0]    in_source_pin,
  input  logic [1:0]         in_pin_levels,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic signed [PosW-1:0] out_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PinW-1:0]    cfg_data
);

  localparam logic [ChanW:0] ChanLimit = (ChanW+1)'(CHANNELS);

  logic [2:0]      chan_count_r;
  logic [PinW-1:0] base_pin_r [NumBasePins];

  logic             s1_valid_r;
  logic [CmdW-1:0]  s1_cmd_r;
  logic [ChanW-1:0] s1_chan_r;
  logic [PinW-1:0]  s1_pin_r;
  logic [1:0]       s1_levels_r;

  logic              out_valid_r;
  logic              out_acc_r;
  logic [PosW-1:0]   out_pos_r;

  logic              out_load, s1_fire;
  logic [PinW-1:0]   sel_base;
  logic              addressable;
  lane_req_t         req;
  lane_stat_t        lane_stat [CHANNELS];
  logic [CHANNELS-1:0] lane_sel;
  lane_stat_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= '0;
      for (int k = 0; k < NumBasePins; k++) begin
        base_pin_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: chan_count_r  <= cfg_data[2:0];
        REG_BASE_PIN_0:    base_pin_r[0] <= cfg_data;
        REG_BASE_PIN_1:    base_pin_r[1] <= cfg_data;
        REG_BASE_PIN_2:    base_pin_r[2] <= cfg_data;
        REG_BASE_PIN_3:    base_pin_r[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request flow
  assign out_load = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r    <= in_command;
      s1_chan_r   <= in_channel;
      s1_pin_r    <= in_source_pin;
      s1_levels_r <= in_pin_levels;
    end
  end

  // decode of the registered request
  assign sel_base    = base_pin_r[s1_chan_r];
  assign addressable = {1'b0, s1_chan_r} < ChanLimit;

  always_comb begin
    req.command    = s1_cmd_r;
    req.phase      = {s1_levels_r[0], s1_levels_r[1]};
    req.configured = addressable && ({1'b0, s1_chan_r} < chan_count_r) && sel_base[PinW-1];
    req.pin_match  = ({1'b0, s1_pin_r} == {1'b0, sel_base}) ||
                     ({1'b0, s1_pin_r} == ({1'b0, sel_base} + (PinW+1)'(1)));
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    assign lane_sel[i] = s1_chan_r == ChanW'(i);
    mcqc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .sel   (s1_fire && lane_sel[i]),
      .req   (req),
      .stat  (lane_stat[i])
    );
  end

  always_comb begin
    res = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (lane_sel[k]) begin
        res = lane_stat[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_acc_r <= res.accepted;
      out_pos_r <= res.position;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_position = signed'(out_pos_r);

  a_lane_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(lane_sel))
    else $error("more than one lane selected");

  a_unaddressable_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !addressable |=> !out_acc_r && out_pos_r == '0)
    else $error("unaddressable channel gave a result");

  a_edge_needs_config: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_cmd_r == CMD_EDGE && !(req.configured && req.pin_match) |=> !out_acc_r)
    else $error("edge counted on unconfigured channel or wrong pin");

  a_unknown_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_cmd_r > CMD_DISABLE |=> !out_acc_r)
    else $error("unknown command accepted");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("request lost between stages");

endmodule

>>> tb/sv/tb_multi_channel_quadrature_counter.sv
// tb_multi_channel_quadrature_counter: self-checking bench for the x4 quadrature counter
// predicts the count and accept flag of every request and checks each result in order
// depends on mcqc_pkg and the multi_channel_quadrature_counter rtl
module tb_multi_channel_quadrature_counter;
  import mcqc_pkg::*;

  localparam int NumChan = 4;
  localparam int DrainLimit = 5000;
  localparam int MaxPrinted = 40;
  localparam logic [CmdW-1:0] CMD_TOP = '1;
  localparam logic [CfgIdxW-1:0] REG_TOP = '1;

  typedef struct packed {
    logic            accepted;
    logic [PosW-1:0] position;
  } count_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CmdW-1:0] in_command = CMD_READ;
  logic [ChanW-1:0] in_channel = '0;
  logic [PinW-1:0] in_source_pin = '0;
  logic [1:0] in_pin_levels = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic out_accepted;
  logic signed [PosW-1:0] out_position;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_CHANNEL_COUNT;
  logic [PinW-1:0] cfg_data = '0;

  // predictor state
  logic [PosW-1:0] enc_count [NumChan];
  logic [1:0] enc_phase [NumChan];
  logic enc_enabled [NumChan];
  logic [2:0] cfg_chan_count;
  logic [PinW-1:0] cfg_base [NumChan];
  count_result_t expected_counts[$];

  // stimulus state
  logic [1:0] gen_phase [NumChan];
  logic gen_back [NumChan];
  int burst_left = 0;
  logic [31:0] stall_pattern = '1;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_pos = 0;

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_counted = 0;

  multi_channel_quadrature_counter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_channel   (in_channel),
    .in_source_pin(in_source_pin),
    .in_pin_levels(in_pin_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accepted (out_accepted),
    .out_position (out_position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // a is the upper pin, so the level bits swap into the phase code
  function automatic logic [1:0] swap_levels(logic [1:0] v);
    return {v[0], v[1]};
  endfunction

  // step between two phases along the forward cycle 0, 2, 3, 1
  function automatic int phase_step(logic [1:0] from, logic [1:0] to);
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] d;
    a = {from[0], from[1] ^ from[0]};
    b = {to[0], to[1] ^ to[0]};
    d = b - a;
    if (d == 2'd1) return 1;
    if (d == 2'd3) return -1;
    return 0;
  endfunction

  function automatic logic chan_configured(logic [ChanW-1:0] ch);
    return ({1'b0, ch} < cfg_chan_count) && cfg_base[ch][PinW-1];
  endfunction

  function automatic count_result_t advance_encoder(logic [CmdW-1:0] cmd, logic [ChanW-1:0] ch,
                                                   logic [PinW-1:0] pin, logic [1:0] lv);
    count_result_t res;
    logic [1:0] ph;
    logic conf;
    logic hit;
    ph = swap_levels(lv);
    conf = chan_configured(ch);
    hit = (pin == cfg_base[ch]) || (int'(pin) == int'(cfg_base[ch]) + 1);
    res.accepted = 1'b0;
    case (cmd)
      CMD_EDGE: begin
        if (conf && enc_enabled[ch] && hit) begin
          enc_count[ch] = enc_count[ch] + PosW'(phase_step(enc_phase[ch], ph));
          enc_phase[ch] = ph;
          res.accepted = 1'b1;
        end
      end
      CMD_READ: res.accepted = 1'b1;
      CMD_RESET: begin
        enc_count[ch] = '0;
        if (conf) enc_phase[ch] = ph;
        res.accepted = 1'b1;
      end
      CMD_ENABLE: begin
        if (conf) begin
          enc_phase[ch] = ph;
          enc_count[ch] = '0;
          enc_enabled[ch] = 1'b1;
          res.accepted = 1'b1;
        end
      end
      CMD_DISABLE: begin
        if (conf) begin
          enc_enabled[ch] = 1'b0;
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    res.position = enc_count[ch];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [PosW-1:0] got,
                                 input logic [PosW-1:0] want);
    errors++;
    if (errors <= MaxPrinted)
      $display("mismatch at %0t: %s, got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : scoreboard
    count_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < NumChan; k++) begin
        enc_count[k] = '0;
        enc_phase[k] = '0;
        enc_enabled[k] = 1'b0;
        cfg_base[k] = '0;
      end
      cfg_chan_count = '0;
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          REG_CHANNEL_COUNT: cfg_chan_count = cfg_data[2:0];
          REG_BASE_PIN_0, REG_BASE_PIN_1, REG_BASE_PIN_2, REG_BASE_PIN_3:
            cfg_base[int'(cfg_index - REG_BASE_PIN_0)] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = advance_encoder(in_command, in_channel, in_source_pin, in_pin_levels);
        expected_counts.push_back(want);
        n_requests++;
        if (in_command == CMD_EDGE && want.accepted) n_counted++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_counts.size() == 0) begin
          report_mismatch("result with no request pending", out_position, '0);
        end else begin
          want = expected_counts.pop_front();
          if (out_accepted !== want.accepted)
            report_mismatch("accepted", PosW'(out_accepted), PosW'(want.accepted));
          if (out_position !== want.position)
            report_mismatch("position", out_position, want.position);
        end
      end
    end
  end

  // result side back-pressure from a randomly re-chosen stall mode and pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_pattern = $urandom;
      if (stall_mode == 3) stall_pattern = stall_pattern & $urandom;
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    out_ready <= (stall_mode == 0) ? 1'b1 : stall_pattern[stall_pos];
    stall_pos = (stall_pos + 1) % 32;
  end

  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [ChanW-1:0] ch,
                              input logic [PinW-1:0] pin, input logic [1:0] lv);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_channel <= ch;
    in_source_pin <= pin;
    in_pin_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [PinW-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // nothing is configured yet, so only read and count reset take effect
  task automatic test_unconfigured_after_reset();
    send_request(CMD_READ, 2'd0, 6'd0, 2'b00);
    send_request(CMD_EDGE, 2'd1, 6'd0, 2'b11);
    send_request(CMD_ENABLE, 2'd2, 6'd32, 2'b01);
    send_request(CMD_DISABLE, 2'd3, 6'd63, 2'b10);
    send_request(CMD_RESET, 2'd0, 6'd0, 2'b11);
    for (int c = int'(CMD_DISABLE) + 1; c <= int'(CMD_TOP); c++)
      send_request(CmdW'(c), 2'd1, 6'd63, 2'b11);
    wait_drained();
  endtask

  // pin bounds on both sides of the unused limit, and writes past the register list
  task automatic test_register_extremes();
    cfg_write(REG_CHANNEL_COUNT, 6'd4);
    cfg_write(REG_BASE_PIN_0, 6'd32);
    cfg_write(REG_BASE_PIN_1, 6'd63);
    cfg_write(REG_BASE_PIN_2, 6'd0);
    cfg_write(REG_BASE_PIN_3, 6'd31);
    for (int r = int'(REG_BASE_PIN_3) + 1; r <= int'(REG_TOP); r++)
      cfg_write(CfgIdxW'(r), 6'd63);
    send_request(CMD_ENABLE, 2'd0, 6'd0, 2'b00);
    send_request(CMD_ENABLE, 2'd1, 6'd0, 2'b11);
    send_request(CMD_ENABLE, 2'd2, 6'd0, 2'b00);
    send_request(CMD_ENABLE, 2'd3, 6'd31, 2'b00);
    wait_drained();
  endtask

  // full forward turn, a step back through zero, a skipped phase, pin mismatches
  task automatic test_edge_sequences();
    send_request(CMD_EDGE, 2'd0, 6'd32, 2'b01);
    send_request(CMD_EDGE, 2'd0, 6'd33, 2'b11);
    send_request(CMD_EDGE, 2'd0, 6'd32, 2'b10);
    send_request(CMD_EDGE, 2'd0, 6'd33, 2'b00);
    send_request(CMD_EDGE, 2'd0, 6'd32, 2'b10);
    send_request(CMD_EDGE, 2'd0, 6'd33, 2'b01);
    send_request(CMD_EDGE, 2'd0, 6'd34, 2'b11);
    send_request(CMD_EDGE, 2'd1, 6'd63, 2'b01);
    send_request(CMD_EDGE, 2'd1, 6'd0, 2'b00);
    send_request(CMD_DISABLE, 2'd0, 6'd0, 2'b00);
    send_request(CMD_EDGE, 2'd0, 6'd32, 2'b11);
    send_request(CMD_RESET, 2'd0, 6'd0, 2'b00);
    send_request(CMD_READ, 2'd1, 6'd0, 2'b00);
    wait_drained();
  endtask

  // mostly legal encoder motion on randomly configured channels, mixed with noise and commands
  task automatic test_random_phases();
    logic [CmdW-1:0] cmd;
    logic [ChanW-1:0] ch;
    logic [PinW-1:0] pin;
    logic [1:0] lv;
    int r;
    int count;
    int total;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      count = (ph == 0) ? 7 : (ph == 1) ? 0 : $urandom_range(1, 4);
      total = (ph == 1) ? 100 : 290;
      cfg_write(REG_CHANNEL_COUNT, PinW'(count));
      for (int k = 0; k < NumChan; k++)
        cfg_write(CfgIdxW'(int'(REG_BASE_PIN_0) + k),
                  ($urandom_range(0, 3) == 0) ? PinW'($urandom_range(0, 31))
                                              : PinW'($urandom_range(32, 63)));
      for (int k = 0; k < NumChan; k++) begin
        lv = 2'($urandom);
        gen_phase[k] = swap_levels(lv);
        gen_back[k] = 1'($urandom);
        send_request(CMD_ENABLE, ChanW'(k), PinW'($urandom), lv);
      end
      for (int i = 0; i < total; i++) begin
        ch = ChanW'($urandom);
        r = $urandom_range(0, 99);
        cmd = CMD_EDGE;
        pin = PinW'($urandom);
        lv = 2'($urandom);
        if (r < 70) begin
          if ($urandom_range(0, 9) == 0) gen_back[ch] = !gen_back[ch];
          gen_phase[ch] ^= ((gen_phase[ch][0] == gen_phase[ch][1]) ^ gen_back[ch]) ? 2'b10 : 2'b01;
          lv = swap_levels(gen_phase[ch]);
          pin = cfg_base[ch] + PinW'($urandom_range(0, 1));
        end else if (r < 78) begin
          cmd = CMD_EDGE;
        end else if (r < 84) begin
          cmd = CMD_READ;
        end else if (r < 89) begin
          cmd = CMD_RESET;
        end else if (r < 93) begin
          cmd = CMD_ENABLE;
        end else if (r < 97) begin
          cmd = CMD_DISABLE;
        end else begin
          cmd = CmdW'($urandom_range(int'(CMD_DISABLE) + 1, int'(CMD_TOP)));
        end
        if (cmd == CMD_RESET || cmd == CMD_ENABLE) gen_phase[ch] = swap_levels(lv);
        send_request(cmd, ch, pin, lv);
      end
    end
  endtask

  initial begin
    count_result_t left;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_unconfigured_after_reset();
    test_register_extremes();
    test_edge_sequences();
    test_random_phases();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int i = 0; i < DrainLimit && expected_counts.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    while (expected_counts.size() != 0) begin
      left = expected_counts.pop_front();
      report_mismatch("result never arrived", 'x, left.position);
    end
    $display("covered %0d requests and %0d results over %0d register writes",
             n_requests, n_results, n_writes);
    $display("%0d edges counted, %0d mismatches", n_counted, errors);
    if (errors == 0) begin
      $display("PASS multi_channel_quadrature_counter");
    end else begin
      $display("FAIL multi_channel_quadrature_counter");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results pending", expected_counts.size());
    $display("FAIL multi_channel_quadrature_counter");
    $finish;
  end

endmodule
